@@ src/dsfs_pkg.sv @@
// Shared types and constants of the dirty span flush sequencer.
package dsfs_pkg;

   // Panel command codes
   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

   localparam logic [3:0] CHUNK_ROWS_MAX = 4'd8;

   // Register reset values
   localparam logic [7:0] COLUMN_OFFSET_RST = 8'd0;
   localparam logic [7:0] ROW_OFFSET_RST    = 8'd24;
   localparam logic [3:0] CHUNK_ROWS_RST    = 4'd8;

   // Register indexes
   localparam int         CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLUMN_OFFSET = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_OFFSET    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHUNK_ROWS    = 2'd2;
   localparam int         CSR_DATA_W = 8;

   // Request operation codes
   localparam logic OP_MARK = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Stream widths
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 3;

   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_WINDOW  = 2'd1,
      KIND_CHUNK   = 2'd2,
      KIND_DONE    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STEP_IDLE      = 3'd0,
      STEP_COL_CMD   = 3'd1,
      STEP_COL_WIN   = 3'd2,
      STEP_ROW_CMD   = 3'd3,
      STEP_ROW_WIN   = 3'd4,
      STEP_MEMWR_CMD = 3'd5,
      STEP_PIXELS    = 3'd6
   } step_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MARK,
      ST_DRAIN,
      ST_FIND,
      ST_SEED,
      ST_MERGE,
      ST_START,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load_req;
      logic mark_step;
      logic scan_reset;
      logic scan_skip;
      logic scan_hit;
      logic seed;
      logic merge_ok;
      logic start_flush;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic rect_ok;
      logic link_idle;
      logic flush_active;
      logic mark_last;
      logic scan_end;
      logic row_dirty;
      logic merge_match;
      logic out_free;
   } dp_status_type;

endpackage

@@ src/dsfs_ctrl.sv @@
// Controller state machine of the dirty span flush sequencer.
module dsfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output dsfs_pkg::dp_cmd_type   cmd,
   input  dsfs_pkg::dp_status_type sts
);
   import dsfs_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            priority if (!sts.is_tick) begin
               state_in = sts.rect_ok ? ST_MARK : ST_IDLE;
            end else if (!sts.link_idle) begin
               state_in = ST_IDLE;
            end else if (sts.flush_active) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_FIND;
            end
         end
         ST_MARK: begin
            if (sts.mark_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_IDLE;
         ST_FIND: begin
            priority if (sts.scan_end) state_in = ST_IDLE;
            else if (sts.row_dirty) state_in = ST_SEED;
         end
         ST_SEED: state_in = sts.scan_end ? ST_START : ST_MERGE;
         ST_MERGE: begin
            if (!sts.merge_match || sts.scan_end) state_in = ST_START;
         end
         ST_START: state_in = ST_EMIT;
         ST_EMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_DISPATCH: begin
            cmd.scan_reset = sts.is_tick && sts.link_idle && !sts.flush_active;
         end
         ST_MARK:  cmd.mark_step = 1'b1;
         ST_DRAIN: ;
         ST_FIND: begin
            cmd.scan_hit  = !sts.scan_end && sts.row_dirty;
            cmd.scan_skip = !sts.scan_end && !sts.row_dirty;
         end
         ST_SEED:  cmd.seed = 1'b1;
         ST_MERGE: cmd.merge_ok = sts.merge_match;
         ST_START: cmd.start_flush = 1'b1;
         ST_EMIT:  cmd.emit = sts.out_free;
         default: ;
      endcase
   end

endmodule

@@ src/dsfs_datapath.sv @@
// Datapath: span memory, dirty bits, flush region, registers and result register.
module dsfs_datapath #(
   parameter int SCREEN_WIDTH  = 160,
   parameter int SCREEN_HEIGHT = 128
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dsfs_pkg::dp_cmd_type                   cmd,
   output dsfs_pkg::dp_status_type                sts,
   input  logic [dsfs_pkg::REQ_TDATA_W-1:0]        req_tdata,
   input  logic [dsfs_pkg::REQ_TUSER_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [dsfs_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic [dsfs_pkg::RSP_TUSER_W-1:0]        rsp_tuser,
   input  logic                                   csr_we,
   input  logic [dsfs_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [dsfs_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import dsfs_pkg::*;

   localparam int ROW_W = $clog2(SCREEN_HEIGHT);
   localparam logic [7:0] WIDTH_C   = 8'(SCREEN_WIDTH);
   localparam logic [7:0] HEIGHT_C  = 8'(SCREEN_HEIGHT);
   localparam logic [8:0] LAST_COL  = 9'(SCREEN_WIDTH - 1);
   localparam logic [8:0] LAST_ROW  = 9'(SCREEN_HEIGHT - 1);

   // Configuration registers
   logic [7:0] column_offset_ff, column_offset_in;
   logic [7:0] row_offset_ff, row_offset_in;
   logic [3:0] chunk_rows_ff, chunk_rows_in;

   // Latched request
   logic       op_ff, op_in;
   logic [7:0] rect_x_ff, rect_x_in;
   logic [7:0] rect_y_ff, rect_y_in;
   logic [7:0] rect_w_ff, rect_w_in;
   logic [7:0] rect_h_ff, rect_h_in;
   logic       link_idle_ff, link_idle_in;

   // Walk counter, memory port, dirty bits
   logic [7:0]               row_ff, row_in;
   logic [ROW_W-1:0]         rd_addr_ff, rd_addr_in;
   logic                     pend_ff, pend_in;
   logic [SCREEN_HEIGHT-1:0] dirty_ff, dirty_in;
   logic [15:0]              span_mem [SCREEN_HEIGHT];
   logic [15:0]              rd_data_ff;
   logic                     rd_en;
   logic [15:0]              wr_data;

   // Flush state
   logic       active_ff, active_in;
   step_type   step_ff, step_in;
   logic [7:0] region_col_ff, region_col_in;
   logic [7:0] region_end_ff, region_end_in;
   logic [7:0] region_row_ff, region_row_in;
   logic [7:0] region_height_ff, region_height_in;
   logic [7:0] next_row_ff, next_row_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   kind_ff, kind_in;
   logic       data_mode_ff, data_mode_in;
   logic [7:0] command_byte_ff, command_byte_in;
   logic [15:0] first_coord_ff, first_coord_in;
   logic [15:0] last_coord_ff, last_coord_in;
   logic [7:0] chunk_col_ff, chunk_col_in;
   logic [7:0] chunk_row_ff, chunk_row_in;
   logic [7:0] chunk_width_ff, chunk_width_in;
   logic [3:0] chunk_height_ff, chunk_height_in;

   // Derived values
   logic [8:0] x1_raw, y1_raw;
   logic [7:0] x1, y1;
   logic [7:0] rd_start, rd_end;
   logic [8:0] region_stop;
   logic [8:0] rows_left;
   logic [3:0] limit;
   logic [3:0] rows;
   logic [7:0] region_width;

   assign rd_start = rd_data_ff[15:8];
   assign rd_end   = rd_data_ff[7:0];

   always_comb begin
      x1_raw = {1'b0, rect_x_ff} + {1'b0, rect_w_ff} - 9'd1;
      y1_raw = {1'b0, rect_y_ff} + {1'b0, rect_h_ff} - 9'd1;
      x1 = (x1_raw > LAST_COL) ? LAST_COL[7:0] : x1_raw[7:0];
      y1 = (y1_raw > LAST_ROW) ? LAST_ROW[7:0] : y1_raw[7:0];
   end

   // Widen the span of the row read last cycle
   always_comb begin
      if (!dirty_ff[rd_addr_ff]) begin
         wr_data = {rect_x_ff, x1};
      end else begin
         wr_data[15:8] = (rect_x_ff < rd_start) ? rect_x_ff : rd_start;
         wr_data[7:0]  = (x1 > rd_end) ? x1 : rd_end;
      end
   end

   assign rd_en = cmd.mark_step || cmd.scan_hit
               || ((cmd.seed || cmd.merge_ok) && !sts.scan_end);

   always_comb begin
      sts.is_tick      = (op_ff == OP_TICK);
      sts.rect_ok      = (rect_w_ff != 8'd0) && (rect_h_ff != 8'd0)
                      && (rect_x_ff < WIDTH_C) && (rect_y_ff < HEIGHT_C);
      sts.link_idle    = link_idle_ff;
      sts.flush_active = active_ff;
      sts.mark_last    = (row_ff == y1);
      sts.scan_end     = (row_ff == HEIGHT_C);
      sts.row_dirty    = !sts.scan_end && dirty_ff[row_ff[ROW_W-1:0]];
      sts.merge_match  = dirty_ff[rd_addr_ff] && (rd_start == region_col_ff)
                      && (rd_end == region_end_ff);
      sts.out_free     = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      region_stop  = {1'b0, region_row_ff} + {1'b0, region_height_ff};
      rows_left    = region_stop - {1'b0, next_row_ff};
      region_width = region_end_ff - region_col_ff + 8'd1;
      if (chunk_rows_ff == 4'd0) limit = 4'd1;
      else if (chunk_rows_ff > CHUNK_ROWS_MAX) limit = CHUNK_ROWS_MAX;
      else limit = chunk_rows_ff;
      rows = (rows_left > {5'd0, limit}) ? limit : rows_left[3:0];
   end

   // Next values
   always_comb begin
      column_offset_in = column_offset_ff;
      row_offset_in    = row_offset_ff;
      chunk_rows_in    = chunk_rows_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_COLUMN_OFFSET: column_offset_in = csr_wdata;
            CSR_ROW_OFFSET:    row_offset_in    = csr_wdata;
            CSR_CHUNK_ROWS:    chunk_rows_in    = csr_wdata[3:0];
            default: ;
         endcase
      end

      op_in        = op_ff;
      rect_x_in    = rect_x_ff;
      rect_y_in    = rect_y_ff;
      rect_w_in    = rect_w_ff;
      rect_h_in    = rect_h_ff;
      link_idle_in = link_idle_ff;
      row_in       = row_ff;
      if (cmd.load_req) begin
         op_in        = req_tuser[0];
         rect_x_in    = req_tdata[7:0];
         rect_y_in    = req_tdata[15:8];
         rect_w_in    = req_tdata[23:16];
         rect_h_in    = req_tdata[31:24];
         link_idle_in = req_tdata[32];
         row_in       = req_tdata[15:8];
      end
      if (cmd.scan_reset) row_in = 8'd0;
      if (cmd.scan_skip || rd_en) row_in = row_ff + 8'd1;

      rd_addr_in = rd_en ? row_ff[ROW_W-1:0] : rd_addr_ff;
      pend_in    = cmd.mark_step;

      dirty_in = dirty_ff;
      if (pend_ff) dirty_in[rd_addr_ff] = 1'b1;
      if (cmd.scan_hit) dirty_in[row_ff[ROW_W-1:0]] = 1'b0;
      if (cmd.merge_ok) dirty_in[rd_addr_ff] = 1'b0;

      region_col_in    = region_col_ff;
      region_end_in    = region_end_ff;
      region_row_in    = region_row_ff;
      region_height_in = region_height_ff;
      if (cmd.scan_hit) region_row_in = row_ff;
      if (cmd.seed) begin
         region_col_in    = rd_start;
         region_end_in    = rd_end;
         region_height_in = 8'd1;
      end
      if (cmd.merge_ok) region_height_in = region_height_ff + 8'd1;

      active_in   = active_ff;
      step_in     = step_ff;
      next_row_in = next_row_ff;
      if (cmd.start_flush) begin
         active_in   = 1'b1;
         step_in     = STEP_COL_CMD;
         next_row_in = region_row_ff;
      end

      rsp_valid_in    = rsp_valid_ff;
      kind_in         = kind_ff;
      data_mode_in    = data_mode_ff;
      command_byte_in = command_byte_ff;
      first_coord_in  = first_coord_ff;
      last_coord_in   = last_coord_ff;
      chunk_col_in    = chunk_col_ff;
      chunk_row_in    = chunk_row_ff;
      chunk_width_in  = chunk_width_ff;
      chunk_height_in = chunk_height_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;

      if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         kind_in         = KIND_DONE;
         data_mode_in    = 1'b0;
         command_byte_in = 8'd0;
         first_coord_in  = 16'd0;
         last_coord_in   = 16'd0;
         chunk_col_in    = 8'd0;
         chunk_row_in    = 8'd0;
         chunk_width_in  = 8'd0;
         chunk_height_in = 4'd0;
         unique case (step_ff)
            STEP_COL_CMD: begin
               kind_in = KIND_COMMAND;
               command_byte_in = CMD_COLUMN_SET;
               step_in = STEP_COL_WIN;
            end
            STEP_COL_WIN: begin
               kind_in = KIND_WINDOW;
               data_mode_in = 1'b1;
               first_coord_in = 16'(region_col_ff) + 16'(column_offset_ff);
               last_coord_in  = 16'(region_end_ff) + 16'(column_offset_ff);
               step_in = STEP_ROW_CMD;
            end
            STEP_ROW_CMD: begin
               kind_in = KIND_COMMAND;
               command_byte_in = CMD_ROW_SET;
               step_in = STEP_ROW_WIN;
            end
            STEP_ROW_WIN: begin
               kind_in = KIND_WINDOW;
               data_mode_in = 1'b1;
               first_coord_in = 16'(region_row_ff) + 16'(row_offset_ff);
               last_coord_in  = 16'(region_stop) - 16'd1 + 16'(row_offset_ff);
               step_in = STEP_MEMWR_CMD;
            end
            STEP_MEMWR_CMD: begin
               kind_in = KIND_COMMAND;
               command_byte_in = CMD_MEMORY_WRITE;
               step_in = STEP_PIXELS;
            end
            STEP_PIXELS: begin
               if ({1'b0, next_row_ff} < region_stop) begin
                  kind_in = KIND_CHUNK;
                  data_mode_in = 1'b1;
                  chunk_col_in = region_col_ff;
                  chunk_row_in = next_row_ff;
                  chunk_width_in = region_width;
                  chunk_height_in = rows;
                  next_row_in = next_row_ff + 8'(rows);
               end else begin
                  active_in = 1'b0;
                  step_in = STEP_IDLE;
               end
            end
            default: begin
               // idle or unknown step code: close the flush
               active_in = 1'b0;
               step_in = STEP_IDLE;
            end
         endcase
      end
   end

   // Span memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (pend_ff) span_mem[rd_addr_ff] <= wr_data;
      if (rd_en) rd_data_ff <= span_mem[row_ff[ROW_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_offset_ff <= COLUMN_OFFSET_RST;
         row_offset_ff    <= ROW_OFFSET_RST;
         chunk_rows_ff    <= CHUNK_ROWS_RST;
         pend_ff          <= 1'b0;
         dirty_ff         <= '0;
         active_ff        <= 1'b0;
         step_ff          <= STEP_IDLE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         column_offset_ff <= column_offset_in;
         row_offset_ff    <= row_offset_in;
         chunk_rows_ff    <= chunk_rows_in;
         pend_ff          <= pend_in;
         dirty_ff         <= dirty_in;
         active_ff        <= active_in;
         step_ff          <= step_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      rect_x_ff        <= rect_x_in;
      rect_y_ff        <= rect_y_in;
      rect_w_ff        <= rect_w_in;
      rect_h_ff        <= rect_h_in;
      link_idle_ff     <= link_idle_in;
      row_ff           <= row_in;
      rd_addr_ff       <= rd_addr_in;
      region_col_ff    <= region_col_in;
      region_end_ff    <= region_end_in;
      region_row_ff    <= region_row_in;
      region_height_ff <= region_height_in;
      next_row_ff      <= next_row_in;
      kind_ff          <= kind_in;
      data_mode_ff     <= data_mode_in;
      command_byte_ff  <= command_byte_in;
      first_coord_ff   <= first_coord_in;
      last_coord_ff    <= last_coord_in;
      chunk_col_ff     <= chunk_col_in;
      chunk_row_ff     <= chunk_row_in;
      chunk_width_ff   <= chunk_width_in;
      chunk_height_ff  <= chunk_height_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {data_mode_ff, kind_ff};
   assign rsp_tdata  = {4'd0, chunk_height_ff, chunk_width_ff, chunk_row_ff, chunk_col_ff,
                        last_coord_ff, first_coord_ff, command_byte_ff};

endmodule

@@ src/dirty_span_flush_sequencer.sv @@
// Top level of the dirty span flush sequencer.
//
// Requests arrive on req_* (tuser = operation: mark a rectangle or tick). A mark
// widens the dirty column span of every screen row it covers; a tick with the
// link idle advances the flush and yields at most one result on rsp_*.
// Results: column command, column window, row command, row window, memory-write
// command, pixel chunk descriptors, then a done result, one per tick.
// Requests are taken one at a time. A mark walks the rows it covers, one row
// read per cycle from the span memory (one write port, one read port).
// A tick that opens a flush scans for the first dirty row one row per cycle
// and merges following rows one per cycle, each row visited once.
// Reset clears all spans (dirty bits in flip-flops), ends any flush and loads
// the register defaults; no memory sweep is needed.
// A result waits in the output register while rsp_tready is low; new requests
// are still taken, and only a tick that must emit waits for the register.
module dirty_span_flush_sequencer #(
   parameter int SCREEN_WIDTH  = 160,
   parameter int SCREEN_HEIGHT = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rect_x, rect_y, rect_w, rect_h, link_idle, zero pad
   input  logic [dsfs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // operation
   input  logic [dsfs_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // command_byte, first_coord, last_coord, chunk_col, chunk_row,
   // chunk_width, chunk_height, zero pad
   output logic [dsfs_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // kind, data_mode
   output logic [dsfs_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input  logic                              csr_we,
   input  logic [dsfs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [dsfs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dsfs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   dsfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   dsfs_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // A result is loaded only into a free output slot
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded over a pending result");

   // A loaded result is offered on the next cycle
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("emitted result not presented");

   // A flush is never opened while another is running
   a_start_once: assert property (@(posedge clock) disable iff (reset)
      cmd.start_flush |-> !sts.flush_active)
      else $error("flush started while one is active");

endmodule

@@ tb/flush_result_checker.sv @@
// Checker for the dirty span flush sequencer: predicts panel ops and compares them.
`timescale 1ns / 100ps

module flush_result_checker #(
   parameter int SCREEN_WIDTH  = 160,
   parameter int SCREEN_HEIGHT = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // rect_x, rect_y, rect_w, rect_h, link_idle, zero pad
   input  logic [dsfs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation
   input  logic [dsfs_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // command_byte, first_coord, last_coord, chunk_col, chunk_row,
   // chunk_width, chunk_height, zero pad
   input  logic [dsfs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // kind, data_mode
   input  logic [dsfs_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                             csr_we,
   input  logic [dsfs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dsfs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               pending_count,
   output int                               fail_count
);
   import dsfs_pkg::*;

   localparam logic [7:0] SPAN_CLEAN = 8'hFF;
   localparam int         MAX_REPORTS = 10;

   typedef struct packed {
      kind_type    kind;
      logic        data_mode;
      logic [7:0]  cmd;
      logic [15:0] first_coord;
      logic [15:0] last_coord;
      logic [7:0]  chunk_col;
      logic [7:0]  chunk_row;
      logic [7:0]  chunk_width;
      logic [3:0]  chunk_height;
   } panel_op_type;

   logic [7:0] col_off;
   logic [7:0] row_off;
   logic [3:0] chunk_cfg;

   logic [7:0] span_lo [SCREEN_HEIGHT];
   logic [7:0] span_hi [SCREEN_HEIGHT];
   logic       flushing;
   step_type   step;
   logic [7:0] reg_col;
   logic [7:0] reg_row;
   logic [7:0] reg_w;
   logic [7:0] reg_h;
   logic [7:0] row_next;

   panel_op_type panel_ops_due [$];
   int           mismatches;

   function automatic string describe(panel_op_type op);
      return $sformatf("kind %0d mode %0b cmd %h win %0d..%0d chunk c%0d r%0d w%0d h%0d",
                       op.kind, op.data_mode, op.cmd, op.first_coord, op.last_coord,
                       op.chunk_col, op.chunk_row, op.chunk_width, op.chunk_height);
   endfunction

   // Advance the span/flush model by one accepted request.
   task automatic apply_request(input logic op, input logic [REQ_TDATA_W-1:0] d);
      int           x, y, w, h, x1, y1, r, first, stop, v, rows, lim, row_end;
      logic         finished;
      panel_op_type res;
      x = d[7:0];
      y = d[15:8];
      w = d[23:16];
      h = d[31:24];
      if (op == OP_MARK) begin
         if (w == 0 || h == 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT)
            return;
         x1 = x + w - 1;
         if (x1 > SCREEN_WIDTH - 1) x1 = SCREEN_WIDTH - 1;
         y1 = y + h - 1;
         if (y1 > SCREEN_HEIGHT - 1) y1 = SCREEN_HEIGHT - 1;
         for (r = y; r <= y1; r++) begin
            if (span_lo[r] == SPAN_CLEAN) begin
               span_lo[r] = 8'(x);
               span_hi[r] = 8'(x1);
            end else begin
               if (x < span_lo[r]) span_lo[r] = 8'(x);
               if (x1 > span_hi[r]) span_hi[r] = 8'(x1);
            end
         end
         return;
      end
      if (!d[32])
         return;
      if (!flushing) begin
         first = 0;
         while (first < SCREEN_HEIGHT && span_lo[first] == SPAN_CLEAN) first++;
         if (first >= SCREEN_HEIGHT)
            return;
         // rows below with the very same span join the region
         stop = first + 1;
         while (stop < SCREEN_HEIGHT && span_lo[stop] != SPAN_CLEAN &&
                span_lo[stop] == span_lo[first] && span_hi[stop] == span_hi[first])
            stop++;
         reg_col  = span_lo[first];
         reg_w    = 8'(span_hi[first] - span_lo[first] + 1);
         reg_row  = 8'(first);
         reg_h    = 8'(stop - first);
         row_next = 8'(first);
         for (r = first; r < stop; r++) begin
            span_lo[r] = SPAN_CLEAN;
            span_hi[r] = 8'd0;
         end
         step     = STEP_COL_CMD;
         flushing = 1'b1;
      end
      res      = '0;
      finished = 1'b0;
      case (step)
         STEP_COL_CMD: begin
            res.kind = KIND_COMMAND;
            res.cmd  = CMD_COLUMN_SET;
            step     = STEP_COL_WIN;
         end
         STEP_COL_WIN: begin
            res.kind        = KIND_WINDOW;
            res.data_mode   = 1'b1;
            v               = reg_col + col_off;
            res.first_coord = 16'(v);
            v               = reg_col + reg_w - 1 + col_off;
            res.last_coord  = 16'(v);
            step            = STEP_ROW_CMD;
         end
         STEP_ROW_CMD: begin
            res.kind = KIND_COMMAND;
            res.cmd  = CMD_ROW_SET;
            step     = STEP_ROW_WIN;
         end
         STEP_ROW_WIN: begin
            res.kind        = KIND_WINDOW;
            res.data_mode   = 1'b1;
            v               = reg_row + row_off;
            res.first_coord = 16'(v);
            v               = reg_row + reg_h - 1 + row_off;
            res.last_coord  = 16'(v);
            step            = STEP_MEMWR_CMD;
         end
         STEP_MEMWR_CMD: begin
            res.kind = KIND_COMMAND;
            res.cmd  = CMD_MEMORY_WRITE;
            step     = STEP_PIXELS;
         end
         STEP_PIXELS: begin
            row_end = reg_row + reg_h;
            if (row_next < row_end) begin
               lim = chunk_cfg;
               if (lim == 0) lim = 1;
               if (lim > CHUNK_ROWS_MAX) lim = CHUNK_ROWS_MAX;
               rows = row_end - row_next;
               if (rows > lim) rows = lim;
               res.kind         = KIND_CHUNK;
               res.data_mode    = 1'b1;
               res.chunk_col    = reg_col;
               res.chunk_row    = row_next;
               res.chunk_width  = reg_w;
               res.chunk_height = 4'(rows);
               row_next         = 8'(row_next + rows);
            end else begin
               finished = 1'b1;
            end
         end
         default: finished = 1'b1;
      endcase
      if (finished) begin
         res      = '0;
         res.kind = KIND_DONE;
         flushing = 1'b0;
         step     = STEP_IDLE;
      end
      panel_ops_due.push_back(res);
   endtask

   always @(posedge clock) begin
      panel_op_type seen, due;
      if (reset) begin
         col_off   = COLUMN_OFFSET_RST;
         row_off   = ROW_OFFSET_RST;
         chunk_cfg = CHUNK_ROWS_RST;
         for (int r = 0; r < SCREEN_HEIGHT; r++) begin
            span_lo[r] = SPAN_CLEAN;
            span_hi[r] = 8'd0;
         end
         flushing = 1'b0;
         step     = STEP_IDLE;
         reg_col  = 8'd0;
         reg_row  = 8'd0;
         reg_w    = 8'd0;
         reg_h    = 8'd0;
         row_next = 8'd0;
         panel_ops_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_COLUMN_OFFSET: col_off   = csr_wdata[7:0];
               CSR_ROW_OFFSET:    row_off   = csr_wdata[7:0];
               CSR_CHUNK_ROWS:    chunk_cfg = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            apply_request(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            seen              = '0;
            seen.kind         = kind_type'(rsp_tuser[1:0]);
            seen.data_mode    = rsp_tuser[2];
            seen.cmd          = rsp_tdata[7:0];
            seen.first_coord  = rsp_tdata[23:8];
            seen.last_coord   = rsp_tdata[39:24];
            seen.chunk_col    = rsp_tdata[47:40];
            seen.chunk_row    = rsp_tdata[55:48];
            seen.chunk_width  = rsp_tdata[63:56];
            seen.chunk_height = rsp_tdata[67:64];
            if (panel_ops_due.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("%0t: unexpected rsp: %s", $realtime, describe(seen));
               mismatches++;
            end else begin
               due = panel_ops_due.pop_front();
               if (seen !== due) begin
                  if (mismatches < MAX_REPORTS) begin
                     $display("%0t: rsp mismatch, expected %s", $realtime, describe(due));
                     $display("%0t: rsp mismatch, actual   %s", $realtime, describe(seen));
                  end
                  mismatches++;
               end
            end
         end
      end
      pending_count <= panel_ops_due.size();
      fail_count    <= mismatches;
   end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the dirty span flush sequencer: clock, reset, requests, verdict.
`timescale 1ns / 100ps

module tb_top;
   import dsfs_pkg::*;

   localparam int SCREEN_WIDTH  = 160;
   localparam int SCREEN_HEIGHT = 128;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int SETTLE_CYCLES = 300;   // above the worst scan/merge time of one tick
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_ITEMS   = 185;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [REQ_TUSER_W-1:0] req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_we      = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   int results_due;
   int fail_total;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_asked    = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   dirty_span_flush_sequencer #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   flush_result_checker #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .pending_count (results_due),
      .fail_count    (fail_total)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side backpressure; a long hold is requested by bumping hold_asked
   always @(negedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_req(input logic op, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] w, input logic [7:0] h, input logic lnk);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, lnk, h, w, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering requests until every predicted result has been taken
   task automatic drain_results(input int extra);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_due != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_registers(input logic [7:0] col, input logic [7:0] row,
                                input logic [7:0] chunk, input logic poke_unused);
      write_csr(CSR_COLUMN_OFFSET, col);
      write_csr(CSR_ROW_OFFSET, row);
      write_csr(CSR_CHUNK_ROWS, chunk);
      if (poke_unused)
         write_csr(CSR_UNUSED, 8'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(input int n_items, input int send_pct, input int stall,
                             input logic long_hold, input logic mid_pause);
      int         sent, n, k;
      logic       held, paused;
      logic [7:0] x, y, w, h;
      send_idle_pct = send_pct;
      stall_pct     = stall;
      sent          = 0;
      held          = 1'b0;
      paused        = 1'b0;
      while (sent < n_items) begin
         if (long_hold && !held && sent >= 20) begin
            hold_asked++;
            held = 1'b1;
         end
         if (mid_pause && !paused && sent >= n_items / 2) begin
            drain_results(0);
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 10) begin
            // noise: anything the fields allow
            send_req(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 1'($urandom));
            sent++;
         end else begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
               x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 165));
               y = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 131));
               w = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 40));
               h = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40))
                                               : 8'($urandom_range(1, 12));
               send_req(OP_MARK, x, y, w, h, 1'($urandom));
               sent++;
            end
            n = $urandom_range(4, 18);
            for (k = 0; k < n; k++) begin
               send_req(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        $urandom_range(0, 99) < 85);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, register defaults, no idling
      send_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);          // nothing dirty yet
      send_req(OP_MARK, 8'd20, 8'd5, 8'd0, 8'd4, 1'b1);         // zero width
      send_req(OP_MARK, 8'd20, 8'd5, 8'd4, 8'd0, 1'b0);         // zero height
      send_req(OP_MARK, 8'd160, 8'd5, 8'd4, 8'd4, 1'b1);        // right of screen
      send_req(OP_MARK, 8'd20, 8'd128, 8'd4, 8'd4, 1'b1);       // below screen
      send_req(OP_MARK, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_req(OP_MARK, 8'd150, 8'd120, 8'd255, 8'd255, 1'b0);  // clipped at both edges
      send_req(OP_MARK, 8'd0, 8'd0, 8'd1, 8'd1, 1'b1);
      send_req(OP_MARK, 8'd0, 8'd1, 8'd1, 8'd3, 1'b1);
      send_req(OP_MARK, 8'd10, 8'd0, 8'd5, 8'd1, 1'b1);         // widen row 0 only
      send_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);          // link busy
      repeat (3) send_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      send_req(OP_MARK, 8'd0, 8'd100, 8'd160, 8'd2, 1'b1);      // mark while flushing
      repeat (11) send_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      drain_results(SETTLE_CYCLES);

      set_registers(8'd255, 8'd255, 8'd1, 1'b0);
      run_random(PHASE_ITEMS, 0, 0, 1'b0, 1'b0);
      drain_results(SETTLE_CYCLES);

      set_registers(8'd0, 8'd0, 8'd8, 1'b0);
      run_random(PHASE_ITEMS, 70, 0, 1'b0, 1'b0);
      drain_results(SETTLE_CYCLES);

      // chunk size zero behaves as one row
      set_registers(8'($urandom), 8'($urandom), 8'd0, 1'b1);
      run_random(PHASE_ITEMS, 0, 70, 1'b1, 1'b0);
      drain_results(SETTLE_CYCLES);

      // oversized chunk limit, junk in the unused upper bits
      set_registers(8'($urandom), 8'($urandom),
                    {4'($urandom), 4'($urandom_range(9, 15))}, 1'b0);
      run_random(PHASE_ITEMS, 33, 33, 1'b0, 1'b1);
      drain_results(SETTLE_CYCLES);

      set_registers(8'($urandom), 8'($urandom), 8'($urandom_range(2, 7)), 1'b0);
      run_random(PHASE_ITEMS, 0, 0, 1'b0, 1'b0);
      drain_results(SETTLE_CYCLES);

      if (fail_total == 0 && results_due == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
src/dsfs_pkg.sv
src/dsfs_ctrl.sv
src/dsfs_datapath.sv
src/dirty_span_flush_sequencer.sv
tb/flush_result_checker.sv
tb/tb_top.sv
